// ===== hdl/ecta_pkg.sv =====
package ecta_pkg;

  localparam int unsigned FUNC_W   = 6;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned CHILD_W  = 33;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned STATUS_W = 3;
  // ids are FUNC_W bits wide, so no more totals than this are ever addressed
  localparam int unsigned MAX_IDS  = 64;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_PUSHED    = 3'd0;
  localparam status_t ST_ACCOUNTED = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_BACKWARDS = 3'd4;

  // event class decided by the front end from its own frame count
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_OVERFLOW,
    OP_UNDERFLOW,
    OP_POP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [FUNC_W-1:0] func_id;
    logic [TS_W-1:0]   timestamp;
  } item_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func_id;
    logic [TS_W-1:0]    start;
    logic [CHILD_W-1:0] child;
  } frame_t;

  typedef struct packed {
    status_t            status;
    logic [FUNC_W-1:0]  frame_id;
    logic [TOTAL_W-1:0] total_time;
    logic [LEVEL_W-1:0] stack_level;
  } result_t;

endpackage

// ===== hdl/ecta_ram.sv =====
module ecta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ecta_fifo.sv =====
module ecta_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== hdl/ecta_front.sv =====
module ecta_front #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_kind_i,
  input  logic [ecta_pkg::FUNC_W-1:0]   in_func_id_i,
  input  logic [ecta_pkg::TS_W-1:0]     in_timestamp_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output ecta_pkg::item_t               q_item_o,
  output logic [CW-1:0]                 q_level_o
);

  logic [CW-1:0]   count_q, count_d;
  ecta_pkg::op_e   op;
  logic            full, empty, accept;

  assign full   = (count_q == CW'(STACK_DEPTH));
  assign empty  = (count_q == '0);
  assign accept = in_valid_i && q_ready_i;

  // the frame count follows from the event sequence alone, so it is tracked here
  always_comb begin
    count_d = count_q;
    op      = ecta_pkg::OP_PUSH;
    if (!in_kind_i) begin
      if (full) begin
        op = ecta_pkg::OP_OVERFLOW;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (empty) begin
      op = ecta_pkg::OP_UNDERFLOW;
    end else begin
      op      = ecta_pkg::OP_POP;
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  assign in_ready_o          = q_ready_i;
  assign q_valid_o           = in_valid_i;
  assign q_item_o.op         = op;
  assign q_item_o.func_id    = in_func_id_i;
  assign q_item_o.timestamp  = in_timestamp_i;
  assign q_level_o           = count_d;

endmodule

// ===== hdl/ecta_back.sv =====
module ecta_back #(
  parameter int unsigned NUM_FUNCS   = 64,
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  ecta_pkg::item_t   q_item_i,
  input  logic [CW-1:0]     q_level_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ecta_pkg::result_t res_o
);

  localparam int unsigned SAW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned TOT_DEPTH =
    (NUM_FUNCS < ecta_pkg::MAX_IDS) ? NUM_FUNCS : ecta_pkg::MAX_IDS;
  localparam int unsigned TAW       = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;
  localparam int unsigned FW        = ecta_pkg::FUNC_W;
  localparam int unsigned CHW       = ecta_pkg::CHILD_W;
  localparam int unsigned TW        = ecta_pkg::TOTAL_W;
  localparam int unsigned LW        = ecta_pkg::LEVEL_W;
  localparam logic [FW:0] TOT_LIM   = (FW + 1)'(TOT_DEPTH);

  typedef enum logic {
    S_FETCH,
    S_WRITE
  } state_e;

  state_e            state_q;
  logic              res_valid_q;
  logic [TOT_DEPTH-1:0] tot_vld_q;

  // top frame is held in registers, the frames below it live in the stack memory
  ecta_pkg::frame_t  top_q;
  ecta_pkg::item_t   item_q;
  logic [CW-1:0]     lvl_q;
  logic [FW-1:0]     tid_q;
  logic              tid_ok_q;
  logic              back_q;
  logic [CHW-1:0]    interval_q;
  logic [CHW-1:0]    excl_q;
  ecta_pkg::result_t res_q;

  logic              take, fire;
  logic [FW-1:0]     tid;
  logic              tid_ok;
  logic              backwards;
  logic [ecta_pkg::TS_W-1:0] diff;
  logic [CHW-1:0]    interval, excl;
  logic [CW-1:0]     lvl_m1, lvl_m2;

  logic              stk_re, stk_we;
  ecta_pkg::frame_t  stk_rdata;
  logic              tot_re, tot_we;
  logic [TW-1:0]     tot_rdata;

  logic [TW-1:0]     tot_cur, tot_new;
  logic [TW:0]       tot_sum;
  logic [CHW:0]      child_sum;
  logic [CHW-1:0]    child_new;
  logic              acct;
  logic [CW+LW-1:0]  lvl_ext;
  ecta_pkg::result_t res_d;

  assign q_ready_o = (state_q == S_FETCH);
  assign take      = q_valid_i && q_ready_o;
  assign fire      = (state_q == S_WRITE) && (!res_valid_q || res_ready_i);

  // fetch: classify the total id, start both memory reads, size the interval
  always_comb begin
    if (q_item_i.op == ecta_pkg::OP_PUSH || q_item_i.op == ecta_pkg::OP_OVERFLOW) begin
      tid = q_item_i.func_id;
    end else begin
      tid = top_q.func_id;
    end
  end

  assign tid_ok    = ({1'b0, tid} < TOT_LIM) && (q_item_i.op != ecta_pkg::OP_UNDERFLOW);
  assign backwards = (q_item_i.timestamp < top_q.start);
  assign diff      = q_item_i.timestamp - top_q.start;
  assign interval  = {1'b0, diff} + CHW'(1);
  assign excl      = (top_q.child > interval) ? '0 : interval - top_q.child;
  assign lvl_m1    = q_level_i - CW'(1);
  assign lvl_m2    = lvl_q - CW'(2);

  assign stk_re = take && (q_item_i.op == ecta_pkg::OP_POP) && (q_level_i != '0);
  assign tot_re = take && tid_ok;

  // write-back: saturating updates of the total and of the new top's child time
  assign tot_cur   = (tid_ok_q && tot_vld_q[tid_q[TAW-1:0]]) ? tot_rdata : '0;
  assign tot_sum   = {1'b0, tot_cur} + (TW + 1)'(excl_q);
  assign tot_new   = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
  assign child_sum = {1'b0, stk_rdata.child} + {1'b0, interval_q};
  assign child_new = child_sum[CHW] ? '1 : child_sum[CHW-1:0];
  assign acct      = (item_q.op == ecta_pkg::OP_POP) && !back_q;

  assign tot_we = fire && acct && tid_ok_q;
  assign stk_we = fire && (item_q.op == ecta_pkg::OP_PUSH) && (lvl_q > CW'(1));
  assign lvl_ext = (CW + LW)'(lvl_q);

  always_comb begin
    res_d             = '0;
    res_d.stack_level = lvl_ext[LW-1:0];
    unique case (item_q.op)
      ecta_pkg::OP_PUSH: begin
        res_d.status     = ecta_pkg::ST_PUSHED;
        res_d.frame_id   = item_q.func_id;
        res_d.total_time = tot_cur;
      end
      ecta_pkg::OP_OVERFLOW: begin
        res_d.status     = ecta_pkg::ST_OVERFLOW;
        res_d.frame_id   = item_q.func_id;
        res_d.total_time = tot_cur;
      end
      ecta_pkg::OP_UNDERFLOW: begin
        res_d.status      = ecta_pkg::ST_UNDERFLOW;
        res_d.stack_level = '0;
      end
      ecta_pkg::OP_POP: begin
        res_d.frame_id = top_q.func_id;
        if (back_q) begin
          res_d.status     = ecta_pkg::ST_BACKWARDS;
          res_d.total_time = tot_cur;
        end else begin
          res_d.status     = ecta_pkg::ST_ACCOUNTED;
          res_d.total_time = tid_ok_q ? tot_new : '0;
        end
      end
      default: begin
        res_d.status = ecta_pkg::ST_UNDERFLOW;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      res_valid_q <= 1'b0;
      tot_vld_q   <= '0;
    end else begin
      unique case (state_q)
        S_FETCH: begin
          if (res_valid_q && res_ready_i) begin
            res_valid_q <= 1'b0;
          end
          if (take) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (fire) begin
            state_q     <= S_FETCH;
            res_valid_q <= 1'b1;
          end
          if (tot_we) begin
            tot_vld_q[tid_q[TAW-1:0]] <= 1'b1;
          end
        end
        default: begin
          state_q <= S_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q     <= q_item_i;
      lvl_q      <= q_level_i;
      tid_q      <= tid;
      tid_ok_q   <= tid_ok;
      back_q     <= backwards;
      interval_q <= interval;
      excl_q     <= excl;
    end
    if (fire) begin
      res_q <= res_d;
      if (item_q.op == ecta_pkg::OP_PUSH) begin
        top_q.func_id <= item_q.func_id;
        top_q.start   <= item_q.timestamp;
        top_q.child   <= '0;
      end else if (item_q.op == ecta_pkg::OP_POP && lvl_q != '0) begin
        top_q.func_id <= stk_rdata.func_id;
        top_q.start   <= stk_rdata.start;
        top_q.child   <= back_q ? stk_rdata.child : child_new;
      end
    end
  end

  ecta_ram #(
    .WIDTH ($bits(ecta_pkg::frame_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (lvl_m2[SAW-1:0]),
    .wdata_i (top_q),
    .re_i    (stk_re),
    .raddr_i (lvl_m1[SAW-1:0]),
    .rdata_o (stk_rdata)
  );

  ecta_ram #(
    .WIDTH (TW),
    .DEPTH (TOT_DEPTH)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tid_q[TAW-1:0]),
    .wdata_i (tot_new),
    .re_i    (tot_re),
    .raddr_i (tid[TAW-1:0]),
    .rdata_o (tot_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/exclusive_call_time_accumulator_core.sv =====
// exclusive call time accumulator
// s_axis carries call-trace events: tuser is the kind (0 start, 1 end), tdata
// holds the function id and the timestamp. m_axis returns one result per event:
// tuser is the status, tdata holds frame id, exclusive total and stack level.
// a front end classifies each event (push, overflow, underflow, pop) from its
// own frame count and writes it into a two-entry queue; the back end pops the
// queue and runs each event as a fetch step that reads the stack memory and
// the totals memory, then a write-back step that updates both and loads the
// output register. the top frame is kept in registers.
// the back end takes no new event until the read-modify-write of the totals
// memory for the last one is done.
// reset clears the frame count, the result valid flag and the per-id valid
// bits, so every total reads as zero; no clearing pass is needed.
// while m_axis_tready is low the result holds, the back end waits in its
// write-back step and s_axis keeps taking events until the queue is full.
module exclusive_call_time_accumulator_core #(
  parameter int unsigned NUM_FUNCS   = 64,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func_id[5:0], timestamp[37:6]
  input  logic [0:0]  s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // frame_id[5:0], total_time[53:6], stack_level[60:54]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QW = $bits(ecta_pkg::item_t) + CW;

  logic              fq_valid, fq_ready;
  ecta_pkg::item_t   fq_item, bq_item;
  logic [CW-1:0]     fq_level, bq_level;
  logic [QW-1:0]     fq_data, bq_data;
  logic              bq_valid, bq_ready;
  ecta_pkg::result_t res;

  ecta_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (s_axis_tuser[0]),
    .in_func_id_i   (s_axis_tdata[5:0]),
    .in_timestamp_i (s_axis_tdata[37:6]),
    .q_valid_o      (fq_valid),
    .q_ready_i      (fq_ready),
    .q_item_o       (fq_item),
    .q_level_o      (fq_level)
  );

  assign fq_data = {fq_level, fq_item};

  ecta_fifo #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (bq_valid),
    .out_ready_i (bq_ready),
    .out_data_o  (bq_data)
  );

  assign bq_item  = bq_data[$bits(ecta_pkg::item_t)-1:0];
  assign bq_level = bq_data[QW-1:$bits(ecta_pkg::item_t)];

  ecta_back #(
    .NUM_FUNCS   (NUM_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_item_i    (bq_item),
    .q_level_i   (bq_level),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.stack_level, res.total_time, res.frame_id};
  assign m_axis_tuser = res.status;

endmodule

// ===== hdl/ecta_checker.sv =====
module ecta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an end on an empty stack reports no frame, no total and level zero
  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ecta_pkg::ST_UNDERFLOW) |-> (m_axis_tdata == '0))
    else $error("underflow result carries data");

  // once reset has been seen at an edge, no result is offered at the next one
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind exclusive_call_time_accumulator_core ecta_checker u_checker (.*);

// ===== tb/sv/tb_exclusive_call_time_accumulator_core.sv =====
`timescale 1ns / 100ps

module tb_exclusive_call_time_accumulator_core;
  import ecta_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // func_id[5:0], timestamp[37:6]
  logic [0:0]  s_axis_tuser = '0;   // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // frame_id[5:0], total_time[53:6], stack_level[60:54]
  logic [2:0]  m_axis_tuser;        // status[2:0]

  // expected result typed in by hand, travels beside the event it belongs to
  logic    row_typed = 1'b0;
  result_t row_result = '0;

  exclusive_call_time_accumulator_core #(
    .NUM_FUNCS   (MAX_IDS),
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // call stack and per-function totals as the block should hold them
  logic [FUNC_W-1:0]  stk_func  [STACK_DEPTH];
  logic [TS_W-1:0]    stk_start [STACK_DEPTH];
  logic [CHILD_W-1:0] stk_child [STACK_DEPTH];
  int unsigned        open_depth = 0;
  logic [TOTAL_W-1:0] excl_total [MAX_IDS] = '{default: '0};

  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned sent_items = 0;
  int unsigned gen_depth = 0;
  int unsigned nest_goal = 3;
  logic [31:0] now_ticks = '0;

  typedef struct packed {
    logic              kind;
    logic [FUNC_W-1:0] id;
    logic [TS_W-1:0]   ts;
    logic              typed;
    result_t           res;
  } call_row_t;

  call_row_t call_rows [21] = '{
    // end on an empty stack
    '{KIND_END,   6'h2A, 32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 6'd0, 48'd0, 7'd0}},
    // widest interval, end id is ignored
    '{KIND_START, 6'h3F, 32'h0000_0000, 1'b1, '{ST_PUSHED, 6'h3F, 48'd0, 7'd1}},
    '{KIND_END,   6'h2A, 32'hFFFF_FFFF, 1'b1, '{ST_ACCOUNTED, 6'h3F, 48'h1_0000_0000, 7'd0}},
    // three full-length children push the parent's child time to saturation
    '{KIND_START, 6'd0,  32'h0000_0000, 1'b1, '{ST_PUSHED, 6'd0, 48'd0, 7'd1}},
    '{KIND_START, 6'd1,  32'h0000_0000, 1'b1, '{ST_PUSHED, 6'd1, 48'd0, 7'd2}},
    '{KIND_END,   6'd0,  32'hFFFF_FFFF, 1'b1, '{ST_ACCOUNTED, 6'd1, 48'h1_0000_0000, 7'd1}},
    '{KIND_START, 6'd1,  32'h0000_0000, 1'b1, '{ST_PUSHED, 6'd1, 48'h1_0000_0000, 7'd2}},
    '{KIND_END,   6'd0,  32'hFFFF_FFFF, 1'b1, '{ST_ACCOUNTED, 6'd1, 48'h2_0000_0000, 7'd1}},
    '{KIND_START, 6'd2,  32'h0000_0000, 1'b1, '{ST_PUSHED, 6'd2, 48'd0, 7'd2}},
    '{KIND_END,   6'd0,  32'hFFFF_FFFF, 1'b1, '{ST_ACCOUNTED, 6'd2, 48'h1_0000_0000, 7'd1}},
    // child time above the interval clamps the exclusive part to zero
    '{KIND_END,   6'd0,  32'hFFFF_FFFF, 1'b1, '{ST_ACCOUNTED, 6'd0, 48'd0, 7'd0}},
    // end before start
    '{KIND_START, 6'd5,  32'd1000,      1'b1, '{ST_PUSHED, 6'd5, 48'd0, 7'd1}},
    '{KIND_END,   6'd5,  32'd999,       1'b1, '{ST_BACKWARDS, 6'd5, 48'd0, 7'd0}},
    // zero-length call still counts one tick
    '{KIND_START, 6'd5,  32'h8000_0000, 1'b1, '{ST_PUSHED, 6'd5, 48'd0, 7'd1}},
    '{KIND_END,   6'd5,  32'h8000_0000, 1'b1, '{ST_ACCOUNTED, 6'd5, 48'd1, 7'd0}},
    // backwards inner call leaves the parent's child time alone
    '{KIND_START, 6'd7,  32'd10,        1'b1, '{ST_PUSHED, 6'd7, 48'd0, 7'd1}},
    '{KIND_START, 6'd8,  32'd20,        1'b1, '{ST_PUSHED, 6'd8, 48'd0, 7'd2}},
    '{KIND_END,   6'd8,  32'd15,        1'b1, '{ST_BACKWARDS, 6'd8, 48'd0, 7'd1}},
    '{KIND_END,   6'd7,  32'd30,        1'b1, '{ST_ACCOUNTED, 6'd7, 48'd21, 7'd0}},
    '{KIND_START, 6'h15, 32'h5555_5555, 1'b0, '0},
    '{KIND_END,   6'h2A, 32'hAAAA_AAAA, 1'b0, '0}
  };

  function automatic result_t account_event(input logic kind, input logic [FUNC_W-1:0] id,
                                            input logic [TS_W-1:0] ts);
    result_t            r;
    logic [FUNC_W-1:0]  top_id;
    logic [CHILD_W-1:0] span;
    logic [CHILD_W-1:0] own;
    logic [TOTAL_W:0]   tot_sum;
    logic [CHILD_W:0]   child_sum;
    r = '0;
    if (kind == KIND_START) begin
      r.frame_id = id;
      r.total_time = excl_total[id];
      if (open_depth >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        stk_func[open_depth] = id;
        stk_start[open_depth] = ts;
        stk_child[open_depth] = '0;
        open_depth++;
        r.status = ST_PUSHED;
      end
      r.stack_level = 7'(open_depth);
    end else if (open_depth == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      open_depth--;
      top_id = stk_func[open_depth];
      r.frame_id = top_id;
      r.stack_level = 7'(open_depth);
      if (ts < stk_start[open_depth]) begin
        r.status = ST_BACKWARDS;
        r.total_time = excl_total[top_id];
      end else begin
        span = {1'b0, ts} - {1'b0, stk_start[open_depth]} + 33'd1;
        own = (stk_child[open_depth] > span) ? '0 : span - stk_child[open_depth];
        tot_sum = {1'b0, excl_total[top_id]} + {16'd0, own};
        excl_total[top_id] = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
        if (open_depth > 0) begin
          child_sum = {1'b0, stk_child[open_depth-1]} + {1'b0, span};
          stk_child[open_depth-1] = child_sum[CHILD_W] ? '1 : child_sum[CHILD_W-1:0];
        end
        r.status = ST_ACCOUNTED;
        r.total_time = excl_total[top_id];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // scoreboard: results are checked before the event of the same edge is predicted
  always @(posedge clk_i) begin : score
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[53:6], m_axis_tdata[60:54]};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no event pending", m_axis_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.frame_id !== want.frame_id)
            report_mismatch("frame_id", got.frame_id, want.frame_id);
          if (got.total_time !== want.total_time)
            report_mismatch("total_time", got.total_time, want.total_time);
          if (got.stack_level !== want.stack_level)
            report_mismatch("stack_level", got.stack_level, want.stack_level);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = account_event(s_axis_tuser[0], s_axis_tdata[5:0], s_axis_tdata[37:6]);
        pending_results.insert(pending_results.size(), row_typed ? row_result : want);
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_event(input logic kind, input logic [FUNC_W-1:0] id,
                            input logic [TS_W-1:0] ts, input logic typed, input result_t res);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, ts, id};
    row_typed     <= typed;
    row_result    <= res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    if (kind == KIND_START && gen_depth < STACK_DEPTH)
      gen_depth++;
    else if (kind == KIND_END && gen_depth > 0)
      gen_depth--;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // mostly small steps forward, now and then a long jump or a jump anywhere
  function automatic logic [31:0] advance_time();
    case ($urandom_range(0, 19))
      0:       now_ticks = $urandom();
      1:       now_ticks += $urandom_range(0, 32'h00FF_FFFF);
      default: now_ticks += $urandom_range(0, 40);
    endcase
    return now_ticks;
  endfunction

  task automatic fill_past_overflow();
    while (gen_depth < STACK_DEPTH)
      send_event(KIND_START, 6'($urandom()), advance_time(), 1'b0, '0);
    repeat (2) send_event(KIND_START, 6'($urandom()), advance_time(), 1'b0, '0);
    while (gen_depth > 0)
      send_event(KIND_END, 6'($urandom()), advance_time(), 1'b0, '0);
  endtask

  task automatic run_call_traces(input int unsigned stop_at);
    int unsigned pick;
    logic        go_deeper;
    fill_past_overflow();
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // noise: any kind, id and time, ends on an empty stack included
        send_event(1'($urandom()), 6'($urandom()), $urandom(), 1'b0, '0);
      end else begin
        if (gen_depth == 0) begin
          nest_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
          if ($urandom_range(0, 3) == 0)
            now_ticks = $urandom();
        end
        go_deeper = (gen_depth < nest_goal) ? ($urandom_range(0, 3) != 0)
                                            : ($urandom_range(0, 3) == 0);
        if (gen_depth == 0 || go_deeper)
          send_event(KIND_START, 6'($urandom()), advance_time(), 1'b0, '0);
        else
          send_event(KIND_END, 6'($urandom()), advance_time(), 1'b0, '0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 8;
    snk_idle_pct = 61;
    foreach (call_rows[i])
      send_event(call_rows[i].kind, call_rows[i].id, call_rows[i].ts,
                 call_rows[i].typed, call_rows[i].res);
    wait_results_drained();
    gen_depth = open_depth;

    run_call_traces(450);
    src_idle_pct = 61;
    snk_idle_pct = 8;
    run_call_traces(880);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_call_traces(1300);

    // close every open frame
    wait_results_drained();
    while (gen_depth > 0)
      send_event(KIND_END, 6'd0, 32'hFFFF_FFFF, 1'b0, '0);

    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
